### design/jsu_pkg.sv
// Package: transaction types, result kinds and byte tables for the JSON string unescaper.
package jsu_pkg;

    typedef enum logic [2:0] {
        KIND_CHAR      = 3'd0,
        KIND_CLOSED    = 3'd1,
        KIND_INVALID   = 3'd2,
        KIND_TRUNCATED = 3'd3,
        KIND_NONE      = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] code_unit;
        logic        ended_unclosed;
    } char_item_t;

    localparam logic [7:0] CHR_QUOTE     = 8'h22;
    localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHR_SLASH     = 8'h2F;

    localparam logic [2:0] LEAD_INVALID = 3'd6;

    // low 16 bits of the UTF-8 offsets; lengths 2..5 share the same low half
    localparam logic [15:0] OFFSET_LEN1 = 16'h3080;
    localparam logic [15:0] OFFSET_LONG = 16'h2080;

    // Continuation count implied by a lead byte, or LEAD_INVALID.
    function automatic logic [2:0] extra_bytes_of(input logic [7:0] b);
        logic [2:0] ext;
        priority if (b < 8'h80) ext = 3'd0;
        else if (b < 8'hC0)     ext = LEAD_INVALID;
        else if (b < 8'hE0)     ext = 3'd1;
        else if (b < 8'hF0)     ext = 3'd2;
        else if (b < 8'hF8)     ext = 3'd3;
        else if (b < 8'hFC)     ext = 3'd4;
        else if (b < 8'hFE)     ext = 3'd5;
        else                    ext = LEAD_INVALID;
        return ext;
    endfunction

    // Escape letter to character; bit 8 set when the letter is known.
    function automatic logic [8:0] escape_char(input logic [7:0] b);
        logic [8:0] r;
        unique case (b)
            CHR_QUOTE:     r = {1'b1, CHR_QUOTE};
            CHR_BACKSLASH: r = {1'b1, CHR_BACKSLASH};
            CHR_SLASH:     r = {1'b1, CHR_SLASH};
            8'h62:         r = {1'b1, 8'h08};
            8'h66:         r = {1'b1, 8'h0C};
            8'h6E:         r = {1'b1, 8'h0A};
            8'h72:         r = {1'b1, 8'h0D};
            8'h74:         r = {1'b1, 8'h09};
            default:       r = 9'h000;
        endcase
        return r;
    endfunction

endpackage

### design/json_string_utf8_unescape.sv
// JSON string body unescaper and UTF-8 decoder, one byte per cycle while byte_stall is low.
// Takes one byte of a JSON string body per cycle while byte_stall is low (starting after the
// opening quote) and gives at most one result per byte, registered in the cycle after the byte
// is taken when the output is not stalled. The
// decode of a byte is a single pass through the escape table, the lead-byte classifier and
// one 16-bit shift-add-subtract on the code accumulator: a byte is taken every unstalled cycle.
// An output register plus a one-entry skid register let input continue while a result is
// stalled, until a second result is waiting; byte_stall rises only when both hold a result.
module json_string_utf8_unescape (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  jsu_pkg::byte_item_t byte_item,
    output logic                char_valid,
    input  logic                char_stall,
    output jsu_pkg::char_item_t char_item
);
    import jsu_pkg::*;

    logic        esc_reg, esc_next;
    logic [2:0]  rem_reg, rem_next;
    logic [2:0]  len_reg, len_next;
    logic [15:0] acc_reg, acc_next;

    logic        out_valid_reg, out_valid_next;
    char_item_t  out_reg, out_next;
    logic        skid_valid_reg, skid_valid_next;
    char_item_t  skid_reg, skid_next;

    logic        accept, pop, have;
    kind_t       kind;
    logic [15:0] code;
    logic [15:0] acc_shift;
    logic [2:0]  ext;
    logic [8:0]  esc_res;
    logic [7:0]  b;
    logic        last;
    char_item_t  result;

    assign b          = byte_item.data_byte;
    assign last       = byte_item.last_byte;
    assign byte_stall = skid_valid_reg;
    assign accept     = byte_valid && !skid_valid_reg;
    assign pop        = out_valid_reg && !char_stall;
    assign char_valid = out_valid_reg;
    assign char_item  = out_reg;

    assign acc_shift = {acc_reg[9:0], 6'b0} + {8'h00, b};
    assign ext       = extra_bytes_of(b);
    assign esc_res   = escape_char(b);

    always_comb
    begin
        kind     = KIND_NONE;
        code     = 16'h0000;
        have     = 1'b0;
        esc_next = esc_reg;
        rem_next = rem_reg;
        len_next = len_reg;
        acc_next = acc_reg;

        if (rem_reg != 3'd0)
        begin
            acc_next = acc_shift;
            rem_next = rem_reg - 3'd1;
            if (rem_reg == 3'd1)
            begin
                code = acc_shift - ((len_reg == 3'd1) ? OFFSET_LEN1 : OFFSET_LONG);
                kind = KIND_CHAR;
                have = 1'b1;
            end
            else if (last)
            begin
                kind = KIND_TRUNCATED;
                have = 1'b1;
            end
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
            if (esc_res[8])
            begin
                kind = KIND_CHAR;
                code = {8'h00, esc_res[7:0]};
                have = 1'b1;
            end
        end
        else if (b == CHR_QUOTE)
        begin
            kind = KIND_CLOSED;
            have = 1'b1;
        end
        else if (b == CHR_BACKSLASH)
        begin
            esc_next = 1'b1;
        end
        else if (ext == LEAD_INVALID)
        begin
            kind = KIND_INVALID;
            have = 1'b1;
        end
        else if (ext == 3'd0)
        begin
            kind = KIND_CHAR;
            code = {8'h00, b};
            have = 1'b1;
        end
        else if (last)
        begin
            kind = KIND_TRUNCATED;
            have = 1'b1;
        end
        else
        begin
            acc_next = {8'h00, b};
            rem_next = ext;
            len_next = ext;
        end

        if (last && !have)
        begin
            kind = KIND_NONE;
            have = 1'b1;
        end

        // finished sequence, close, error or end of buffer: start a new string body
        if ((have && (kind != KIND_CHAR || rem_reg == 3'd1)) || last)
        begin
            esc_next = 1'b0;
            rem_next = 3'd0;
            len_next = 3'd0;
            acc_next = 16'h0000;
        end

        result.kind           = kind;
        result.code_unit      = code;
        result.ended_unclosed = last && (kind == KIND_CHAR || kind == KIND_NONE);
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_valid_reg && !pop)
        begin
            if (accept && have)
            begin
                skid_valid_next = 1'b1;
                skid_next       = result;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = accept && have;
            out_next       = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg        <= 1'b0;
            rem_reg        <= 3'd0;
            len_reg        <= 3'd0;
            acc_reg        <= 16'h0000;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                esc_reg <= esc_next;
                rem_reg <= rem_next;
                len_reg <= len_next;
                acc_reg <= acc_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output entry");

    a_esc_not_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
        !(esc_reg && rem_reg != 3'd0))
        else $error("escape pending inside a UTF-8 sequence");

    a_rem_within_len: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= len_reg)
        else $error("remaining count exceeds sequence length");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (rem_reg == 3'd0 && !esc_reg && acc_reg == 16'h0000))
        else $error("state not cleared after last byte");

    a_code_only_for_char: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (char_item.kind == KIND_CHAR || char_item.code_unit == 16'h0000))
        else $error("nonzero code unit on a non-character result");

endmodule

### tb/tb_json_string_utf8_unescape.sv
`timescale 1ns / 100ps
// Testbench for json_string_utf8_unescape: byte driver, result monitor and in-line decoder model.
module tb_json_string_utf8_unescape;

    import jsu_pkg::*;

    localparam logic [7:0] ESC_B = 8'h62;
    localparam logic [7:0] ESC_F = 8'h66;
    localparam logic [7:0] ESC_N = 8'h6E;
    localparam logic [7:0] ESC_R = 8'h72;
    localparam logic [7:0] ESC_T = 8'h74;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    byte_item_t byte_item = '0;
    logic       char_valid;
    logic       char_stall = 1'b0;
    char_item_t char_item;

    byte_item_t pending_bytes[$];
    char_item_t expected_chars[$];
    char_item_t want_char;
    int         errors = 0;
    int         cyc = 0;
    logic       steady;

    // decoder state
    logic        esc_open;
    logic [2:0]  cont_left;
    logic [2:0]  seq_extra;
    logic [31:0] code_acc;

    json_string_utf8_unescape DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        cyc <= cyc + 1;

    assign steady = (cyc >= 300) && (cyc < 600);

    function automatic logic [2:0] lead_extra(input logic [7:0] b);
        if (b < 8'h80)
            return 3'd0;
        if (b < 8'hC0)
            return LEAD_INVALID;
        if (b < 8'hE0)
            return 3'd1;
        if (b < 8'hF0)
            return 3'd2;
        if (b < 8'hF8)
            return 3'd3;
        if (b < 8'hFC)
            return 3'd4;
        if (b < 8'hFE)
            return 3'd5;
        return LEAD_INVALID;
    endfunction

    function automatic logic [31:0] utf8_bias(input logic [2:0] n);
        case (n)
            3'd0:    return 32'h00000000;
            3'd1:    return 32'h00003080;
            3'd2:    return 32'h000E2080;
            3'd3:    return 32'h03C82080;
            3'd4:    return 32'hFA082080;
            default: return 32'h82082080;
        endcase
    endfunction

    task automatic clear_decoder();
        esc_open = 1'b0;
        cont_left = 3'd0;
        seq_extra = 3'd0;
        code_acc = 32'd0;
    endtask

    task automatic decode_byte(input byte_item_t it);
        logic [7:0]  b;
        logic        last;
        kind_t       kind;
        logic [15:0] code;
        logic        have;
        logic [2:0]  ext;
        logic [2:0]  n;
        char_item_t  r;
        b = it.data_byte;
        last = it.last_byte;
        kind = KIND_NONE;
        code = 16'd0;
        have = 1'b0;
        if (cont_left != 3'd0)
        begin
            code_acc = (code_acc << 6) + {24'd0, b};
            cont_left = cont_left - 3'd1;
            if (cont_left == 3'd0)
            begin
                n = (seq_extra > 3'd5) ? 3'd5 : seq_extra;
                code = 16'(code_acc - utf8_bias(n));
                kind = KIND_CHAR;
                have = 1'b1;
                clear_decoder();
            end
            else if (last)
            begin
                kind = KIND_TRUNCATED;
                have = 1'b1;
            end
        end
        else if (esc_open)
        begin
            esc_open = 1'b0;
            have = 1'b1;
            kind = KIND_CHAR;
            case (b)
                CHR_QUOTE:     code = 16'(CHR_QUOTE);
                CHR_BACKSLASH: code = 16'(CHR_BACKSLASH);
                CHR_SLASH:     code = 16'(CHR_SLASH);
                ESC_B:         code = 16'h0008;
                ESC_F:         code = 16'h000C;
                ESC_N:         code = 16'h000A;
                ESC_R:         code = 16'h000D;
                ESC_T:         code = 16'h0009;
                default:
                begin
                    have = 1'b0;
                    kind = KIND_NONE;
                end
            endcase
        end
        else if (b == CHR_QUOTE)
        begin
            kind = KIND_CLOSED;
            have = 1'b1;
        end
        else if (b == CHR_BACKSLASH)
            esc_open = 1'b1;
        else
        begin
            ext = lead_extra(b);
            if (ext == LEAD_INVALID)
            begin
                kind = KIND_INVALID;
                have = 1'b1;
            end
            else if (ext == 3'd0)
            begin
                kind = KIND_CHAR;
                code = {8'd0, b};
                have = 1'b1;
            end
            else if (last)
            begin
                kind = KIND_TRUNCATED;
                have = 1'b1;
            end
            else
            begin
                code_acc = {24'd0, b};
                cont_left = ext;
                seq_extra = ext;
            end
        end
        if (last && !have)
        begin
            kind = KIND_NONE;
            have = 1'b1;
        end
        if (kind != KIND_CHAR)
            code = 16'd0;
        if ((have && (kind != KIND_CHAR || last)) || last)
            clear_decoder();
        if (have)
        begin
            r.kind = kind;
            r.code_unit = code;
            r.ended_unclosed = last && (kind == KIND_CHAR || kind == KIND_NONE);
            expected_chars.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic l);
        byte_item_t it;
        it.data_byte = b;
        it.last_byte = l;
        pending_bytes.push_back(it);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            byte_valid <= 1'b0;
        else
        begin
            if (byte_valid && !byte_stall)
                decode_byte(byte_item);
            if (!byte_valid || !byte_stall)
            begin
                if (pending_bytes.size() != 0 && (steady || $urandom_range(99) >= 23))
                begin
                    byte_item <= pending_bytes.pop_front();
                    byte_valid <= 1'b1;
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            char_stall <= 1'b0;
        else
        begin
            char_stall <= !steady && ($urandom_range(99) < 23);
            if (char_valid && !char_stall)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch("unexpected transaction kind", char_item.kind, 0);
                else
                begin
                    want_char = expected_chars.pop_front();
                    if (char_item.kind !== want_char.kind)
                        report_mismatch("kind", char_item.kind, want_char.kind);
                    if (char_item.code_unit !== want_char.code_unit)
                        report_mismatch("code_unit", char_item.code_unit, want_char.code_unit);
                    if (char_item.ended_unclosed !== want_char.ended_unclosed)
                        report_mismatch("ended_unclosed", char_item.ended_unclosed,
                                        want_char.ended_unclosed);
                end
            end
        end
    end

    initial
    begin
        #200000;
        $display("json_string_utf8_unescape regression: fail");
        $finish;
    end

    initial
    begin
        int         pick;
        int         ext;
        int         cut;
        logic       endmark;
        logic [7:0] b;
        clear_decoder();

        // directed
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(CHR_BACKSLASH, 1'b0);
        push_byte(ESC_N, 1'b0);
        push_byte(CHR_BACKSLASH, 1'b0);
        push_byte(8'h71, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(8'hA9, 1'b0);
        push_byte(8'hE2, 1'b0);
        push_byte(CHR_QUOTE, 1'b0);
        push_byte(CHR_BACKSLASH, 1'b0);
        push_byte(8'hFC, 1'b0);
        repeat (5) push_byte(8'hBF, 1'b0);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(8'hE0, 1'b1);
        push_byte(8'h41, 1'b1);
        push_byte(CHR_BACKSLASH, 1'b1);
        push_byte(CHR_QUOTE, 1'b0);

        // random string bodies
        while (pending_bytes.size() < 400)
        begin
            pick = $urandom_range(99);
            endmark = ($urandom_range(19) == 0);
            if (pick < 30)
            begin
                do
                    b = 8'($urandom_range(127));
                while (b == CHR_QUOTE || b == CHR_BACKSLASH);
                push_byte(b, endmark);
            end
            else if (pick < 45)
            begin
                push_byte(CHR_BACKSLASH, 1'b0);
                case ($urandom_range(9))
                    0:       b = CHR_QUOTE;
                    1:       b = CHR_BACKSLASH;
                    2:       b = CHR_SLASH;
                    3:       b = ESC_B;
                    4:       b = ESC_F;
                    5:       b = ESC_N;
                    6:       b = ESC_R;
                    7:       b = ESC_T;
                    default: b = 8'($urandom_range(255));
                endcase
                push_byte(b, endmark);
            end
            else if (pick < 80)
            begin
                ext = $urandom_range(1, 5);
                case (ext)
                    1:       b = 8'hC0 + 8'($urandom_range(31));
                    2:       b = 8'hE0 + 8'($urandom_range(15));
                    3:       b = 8'hF0 + 8'($urandom_range(7));
                    4:       b = 8'hF8 + 8'($urandom_range(3));
                    default: b = 8'hFC + 8'($urandom_range(1));
                endcase
                cut = endmark ? $urandom_range(ext) : ext + 1;
                push_byte(b, cut == 0);
                for (int i = 1; i <= ext && cut != 0; i++)
                begin
                    if ($urandom_range(9) == 0)
                        b = 8'($urandom_range(255));
                    else
                        b = 8'h80 | 8'($urandom_range(63));
                    push_byte(b, i == cut);
                    if (i == cut)
                        break;
                end
            end
            else if (pick < 88)
            begin
                if ($urandom_range(1) == 0)
                    b = 8'h80 + 8'($urandom_range(63));
                else
                    b = 8'hFE + 8'($urandom_range(1));
                push_byte(b, endmark);
            end
            else if (pick < 94)
                push_byte(CHR_QUOTE, 1'b0);
            else
                push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || byte_valid)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("json_string_utf8_unescape regression: pass");
        else
            $display("json_string_utf8_unescape regression: fail");
        $finish;
    end

endmodule

### filelist.f
design/jsu_pkg.sv
design/json_string_utf8_unescape.sv
tb/tb_json_string_utf8_unescape.sv
